>>> sv/tdq_pkg.sv
// Shared types and codes for the transmit descriptor queue.
// No dependencies; imported by tdq_queue, tx_descriptor_queue_top and the bench tb_top.
package tdq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    // Command codes
    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_DONE   = 2'd1;
    localparam logic [1:0] CMD_ERROR  = 2'd2;

    // Submit status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] count;
        logic        notify;
        logic [31:0] tag;
    } desc_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

>>> sv/tx_descriptor_queue_top.sv
// Transmit scheduler: one in-flight slot plus a FIFO of pending descriptors.
// Depends on tdq_pkg and tdq_queue.
//
//  channel  | direction | ports                        | handshake
//  ---------+-----------+------------------------------+----------------
//  command  | in        | s_command .. s_err_dma       | s_valid/s_ready
//  result   | out       | m_status .. m_busy_now       | m_valid/m_ready
//
// One item per cycle sustained while results are accepted; a result passes through the
// input register, then one pass of the scheduler into the result register.
// The scheduler state, counters and queue pointers all update in that one pass.
// Queue reads are prefetched at the next head address from the descriptor RAM.
// Reset clears the in-flight slot, queue pointers and error counters.
// A stalled result holds the pipe; s_ready drops only when both stages are full.
module tx_descriptor_queue_top
    import tdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_buf_addr,
    input  logic [15:0] s_byte_count,
    input  logic        s_wants_notify,
    input  logic [31:0] s_notify_tag,
    input  logic        s_err_overrun,
    input  logic        s_err_framing,
    input  logic        s_err_noise,
    input  logic        s_err_dma,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_start_valid,
    output logic [31:0] m_start_addr,
    output logic [15:0] m_start_count,
    output logic        m_done_valid,
    output logic [31:0] m_done_tag,
    output logic [15:0] m_done_count,
    output logic [31:0] m_overrun_total,
    output logic [31:0] m_framing_total,
    output logic [31:0] m_noise_total,
    output logic [3:0]  m_pending_level,
    output logic        m_busy_now
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    // Input register
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    desc_t       in_desc_reg;
    logic        ovr_reg, frm_reg, nse_reg, dma_reg;

    // Scheduler state
    logic        in_flight_reg, in_flight_next;
    desc_t       cur_reg, cur_next;
    logic [31:0] ovr_ctr_reg, ovr_ctr_next;
    logic [31:0] frm_ctr_reg, frm_ctr_next;
    logic [31:0] nse_ctr_reg, nse_ctr_next;

    // Result register
    logic        m_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic        start_valid_reg, start_valid_next;
    logic [31:0] start_addr_reg, start_addr_next;
    logic [15:0] start_count_reg, start_count_next;
    logic        done_valid_reg, done_valid_next;
    logic [31:0] done_tag_reg, done_tag_next;
    logic [15:0] done_count_reg, done_count_next;
    logic [3:0]  pending_reg;
    logic        busy_reg;

    queue_ctrl_t      q_ctrl, q_req;
    desc_t            q_head;
    logic [LVL_W-1:0] q_level, level_after;
    logic             q_full;
    logic             advance;
    logic             release_slot;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg            <= s_command;
            in_desc_reg.addr   <= s_buf_addr;
            in_desc_reg.count  <= s_byte_count;
            in_desc_reg.notify <= s_wants_notify;
            in_desc_reg.tag    <= s_notify_tag;
            ovr_reg            <= s_err_overrun;
            frm_reg            <= s_err_framing;
            nse_reg            <= s_err_noise;
            dma_reg            <= s_err_dma;
        end
    end

    always_comb begin
        in_flight_next   = in_flight_reg;
        cur_next         = cur_reg;
        ovr_ctr_next     = ovr_ctr_reg;
        frm_ctr_next     = frm_ctr_reg;
        nse_ctr_next     = nse_ctr_reg;
        status_next      = ST_OK;
        start_valid_next = 1'b0;
        start_addr_next  = '0;
        start_count_next = '0;
        done_valid_next  = 1'b0;
        done_tag_next    = '0;
        done_count_next  = '0;
        q_req            = '0;
        release_slot     = 1'b0;

        case (cmd_reg)
            CMD_SUBMIT: begin
                if (in_desc_reg.addr == '0 || in_desc_reg.count == '0) begin
                    status_next = ST_FAULT;
                end else if (!in_flight_reg) begin
                    in_flight_next   = 1'b1;
                    cur_next         = in_desc_reg;
                    start_valid_next = 1'b1;
                    start_addr_next  = in_desc_reg.addr;
                    start_count_next = in_desc_reg.count;
                end else if (q_full) begin
                    status_next = ST_BUSY;
                end else begin
                    q_req.push = 1'b1;
                end
            end
            CMD_DONE: begin
                if (in_flight_reg) begin
                    release_slot = 1'b1;
                    if (cur_reg.notify) begin
                        done_valid_next = 1'b1;
                        done_tag_next   = cur_reg.tag;
                        done_count_next = cur_reg.count;
                    end
                end
            end
            CMD_ERROR: begin
                if (ovr_reg) ovr_ctr_next = ovr_ctr_reg + 1'b1;
                if (frm_reg) frm_ctr_next = frm_ctr_reg + 1'b1;
                if (nse_reg) nse_ctr_next = nse_ctr_reg + 1'b1;
                // drop the current transfer without notice
                release_slot = dma_reg && in_flight_reg;
            end
            default: begin
            end
        endcase

        // Finish the in-flight slot and start the next queued descriptor, if there is one
        if (release_slot) begin
            if (q_level != '0) begin
                q_req.pop        = 1'b1;
                in_flight_next   = 1'b1;
                cur_next         = q_head;
                start_valid_next = 1'b1;
                start_addr_next  = q_head.addr;
                start_count_next = q_head.count;
            end else begin
                in_flight_next = 1'b0;
            end
        end
    end

    assign q_ctrl.push = q_req.push && advance;
    assign q_ctrl.pop  = q_req.pop && advance;

    always_comb begin
        level_after = q_level;
        if (q_req.push) level_after = q_level + 1'b1;
        if (q_req.pop)  level_after = q_level - 1'b1;
    end

    tdq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wdata   (in_desc_reg),
        .head    (q_head),
        .level   (q_level),
        .full    (q_full)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= 1'b0;
            cur_reg       <= '0;
            ovr_ctr_reg   <= '0;
            frm_ctr_reg   <= '0;
            nse_ctr_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                in_flight_reg <= in_flight_next;
                cur_reg       <= cur_next;
                ovr_ctr_reg   <= ovr_ctr_next;
                frm_ctr_reg   <= frm_ctr_next;
                nse_ctr_reg   <= nse_ctr_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            status_reg      <= status_next;
            start_valid_reg <= start_valid_next;
            start_addr_reg  <= start_addr_next;
            start_count_reg <= start_count_next;
            done_valid_reg  <= done_valid_next;
            done_tag_reg    <= done_tag_next;
            done_count_reg  <= done_count_next;
            pending_reg     <= 4'(level_after);
            busy_reg        <= in_flight_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_start_valid   = start_valid_reg;
    assign m_start_addr    = start_addr_reg;
    assign m_start_count   = start_count_reg;
    assign m_done_valid    = done_valid_reg;
    assign m_done_tag      = done_tag_reg;
    assign m_done_count    = done_count_reg;
    assign m_overrun_total = ovr_ctr_reg;
    assign m_framing_total = frm_ctr_reg;
    assign m_noise_total   = nse_ctr_reg;
    assign m_pending_level = pending_reg;
    assign m_busy_now      = busy_reg;

    // Descriptors wait in the queue only behind a transfer in flight
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_flight_reg |-> (q_level == '0))
        else $error("queue holds descriptors while nothing is in flight");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= LVL_W'(QUEUE_DEPTH))
        else $error("queue level exceeds depth");

    // A started transfer leaves the slot busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_valid) |-> m_busy_now)
        else $error("transfer started but slot not busy");

    // A refused submit changes neither the slot nor the queue
    a_refuse_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (status_next == ST_BUSY || status_next == ST_FAULT))
            |=> ($stable(in_flight_reg) && $stable(q_level)))
        else $error("refused submit changed scheduler state");

endmodule

>>> sv/tdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tdq_queue.sv
// Pending descriptor FIFO: RAM storage, head/tail/level pointers, head prefetch.
// Depends on tdq_pkg and tdq_ram.
module tdq_queue
    import tdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  queue_ctrl_t      ctrl,
    input  desc_t            wdata,
    output desc_t            head,
    output logic [LVL_W-1:0] level,
    output logic             full
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [LVL_W-1:0] DEPTH_LVL = LVL_W'(QUEUE_DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             byp_hit_reg;
    desc_t            byp_data_reg;
    desc_t            ram_rdata;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        if (ctrl.pop) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            level_next = level_reg - 1'b1;
        end
        if (ctrl.push) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            level_next = level_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            level_reg   <= '0;
            byp_hit_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            level_reg   <= level_next;
            // forward a write that lands on the slot being read this cycle
            byp_hit_reg <= ctrl.push && (tail_reg == head_next);
        end
        byp_data_reg <= wdata;
    end

    // Read ahead at the next head so the head entry is ready next cycle
    tdq_ram #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctrl.push),
        .waddr (tail_reg),
        .wdata (wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign head  = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign level = level_reg;
    assign full  = (level_reg == DEPTH_LVL);

endmodule

>>> bench/tb_top.sv
// Self-checking bench for tx_descriptor_queue_top: directed and random commands
// against a built-in scheduler predictor. Depends on tdq_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
    import tdq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_RANDOM   = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_CYCLES = 80;
    localparam int STALL_AFTER  = 60;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] buf_addr;
        logic [15:0] byte_count;
        logic        wants_notify;
        logic [31:0] notify_tag;
        logic        err_overrun;
        logic        err_framing;
        logic        err_noise;
        logic        err_dma;
    } cmd_item_t;

    typedef struct {
        logic [1:0]  status;
        logic        start_valid;
        logic [31:0] start_addr;
        logic [15:0] start_count;
        logic        done_valid;
        logic [31:0] done_tag;
        logic [15:0] done_count;
        logic [31:0] overrun_total;
        logic [31:0] framing_total;
        logic [31:0] noise_total;
        logic [3:0]  pending_level;
        logic        busy_now;
    } sched_result_t;

    typedef struct {
        cmd_item_t     item;
        bit            typed;
        sched_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_SUBMIT;
    logic [31:0] s_buf_addr = '0;
    logic [15:0] s_byte_count = '0;
    logic        s_wants_notify = 1'b0;
    logic [31:0] s_notify_tag = '0;
    logic        s_err_overrun = 1'b0;
    logic        s_err_framing = 1'b0;
    logic        s_err_noise = 1'b0;
    logic        s_err_dma = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_start_valid;
    logic [31:0] m_start_addr;
    logic [15:0] m_start_count;
    logic        m_done_valid;
    logic [31:0] m_done_tag;
    logic [15:0] m_done_count;
    logic [31:0] m_overrun_total;
    logic [31:0] m_framing_total;
    logic [31:0] m_noise_total;
    logic [3:0]  m_pending_level;
    logic        m_busy_now;

    tx_descriptor_queue_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_buf_addr      (s_buf_addr),
        .s_byte_count    (s_byte_count),
        .s_wants_notify  (s_wants_notify),
        .s_notify_tag    (s_notify_tag),
        .s_err_overrun   (s_err_overrun),
        .s_err_framing   (s_err_framing),
        .s_err_noise     (s_err_noise),
        .s_err_dma       (s_err_dma),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_start_valid   (m_start_valid),
        .m_start_addr    (m_start_addr),
        .m_start_count   (m_start_count),
        .m_done_valid    (m_done_valid),
        .m_done_tag      (m_done_tag),
        .m_done_count    (m_done_count),
        .m_overrun_total (m_overrun_total),
        .m_framing_total (m_framing_total),
        .m_noise_total   (m_noise_total),
        .m_pending_level (m_pending_level),
        .m_busy_now      (m_busy_now)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Scheduler shadow state
    logic        tx_active = 1'b0;
    desc_t       tx_cur = '0;
    desc_t       tx_backlog[$];
    logic [31:0] overrun_seen = '0;
    logic [31:0] framing_seen = '0;
    logic [31:0] noise_seen = '0;

    stim_row_t     stream[$];
    sched_result_t awaited_results[$];
    sched_result_t expected_now;
    sched_result_t want_now;

    int send_idx = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit stall_done = 1'b0;
    int n_busy = 0;
    int n_fault = 0;
    int n_notice = 0;
    int n_start = 0;
    logic calm;

    // no random idling on either side inside this window
    assign calm = (cycle_cnt >= 400 && cycle_cnt < 900);

    function automatic cmd_item_t mk_cmd(logic [1:0] c, logic [31:0] a, logic [15:0] n,
                                         logic nt, logic [31:0] tg, logic [3:0] flags);
        cmd_item_t it;
        it.command      = c;
        it.buf_addr     = a;
        it.byte_count   = n;
        it.wants_notify = nt;
        it.notify_tag   = tg;
        {it.err_overrun, it.err_framing, it.err_noise, it.err_dma} = flags;
        return it;
    endfunction

    function automatic sched_result_t mk_res(logic [1:0] st, logic sv, logic [31:0] sa,
                                             logic [15:0] sc, logic dv, logic [31:0] dt,
                                             logic [15:0] dc, logic [31:0] ovr,
                                             logic [31:0] frm, logic [31:0] nse,
                                             logic [3:0] lvl, logic busy);
        sched_result_t r;
        r.status        = st;
        r.start_valid   = sv;
        r.start_addr    = sa;
        r.start_count   = sc;
        r.done_valid    = dv;
        r.done_tag      = dt;
        r.done_count    = dc;
        r.overrun_total = ovr;
        r.framing_total = frm;
        r.noise_total   = nse;
        r.pending_level = lvl;
        r.busy_now      = busy;
        return r;
    endfunction

    function automatic void add_row(cmd_item_t it, bit typed, sched_result_t w);
        stim_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = w;
        stream.push_back(row);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF;
            1: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void begin_transfer(desc_t d, inout sched_result_t r);
        tx_active     = 1'b1;
        tx_cur        = d;
        r.start_valid = 1'b1;
        r.start_addr  = d.addr;
        r.start_count = d.count;
    endfunction

    // Advance the shadow scheduler by one command and return what it reports.
    function automatic sched_result_t next_schedule(cmd_item_t it);
        sched_result_t r;
        desc_t d;
        r = mk_res(ST_OK, 1'b0, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0);
        d = {it.buf_addr, it.byte_count, it.wants_notify, it.notify_tag};
        case (it.command)
            CMD_SUBMIT: begin
                if (it.buf_addr == '0 || it.byte_count == '0) begin
                    r.status = ST_FAULT;
                end else if (!tx_active) begin
                    begin_transfer(d, r);
                end else if (tx_backlog.size() >= QUEUE_DEPTH_DEF) begin
                    r.status = ST_BUSY;
                end else begin
                    tx_backlog.push_back(d);
                end
            end
            CMD_DONE: begin
                if (tx_active) begin
                    if (tx_cur.notify) begin
                        r.done_valid = 1'b1;
                        r.done_tag   = tx_cur.tag;
                        r.done_count = tx_cur.count;
                    end
                    tx_active = 1'b0;
                    if (tx_backlog.size() != 0) begin_transfer(tx_backlog.pop_front(), r);
                end
            end
            CMD_ERROR: begin
                if (it.err_overrun) overrun_seen = overrun_seen + 32'd1;
                if (it.err_framing) framing_seen = framing_seen + 32'd1;
                if (it.err_noise) noise_seen = noise_seen + 32'd1;
                // drop the current transfer silently, then pull the next one
                if (it.err_dma && tx_active) begin
                    tx_active = 1'b0;
                    if (tx_backlog.size() != 0) begin_transfer(tx_backlog.pop_front(), r);
                end
            end
            default: ;
        endcase
        r.overrun_total = overrun_seen;
        r.framing_total = framing_seen;
        r.noise_total   = noise_seen;
        r.pending_level = 4'(tx_backlog.size());
        r.busy_now      = tx_active;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, awaited_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Command side: predict on each transfer, then offer the next row or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_now = next_schedule(stream[send_idx].item);
                if (stream[send_idx].typed) expected_now = stream[send_idx].want;
                awaited_results.push_back(expected_now);
                send_idx++;
            end
            if (!s_valid || s_ready) begin
                if (send_idx < stream.size() &&
                    (calm || hold_left != 0 || $urandom_range(0, 99) >= 24)) begin
                    s_valid        <= 1'b1;
                    s_command      <= stream[send_idx].item.command;
                    s_buf_addr     <= stream[send_idx].item.buf_addr;
                    s_byte_count   <= stream[send_idx].item.byte_count;
                    s_wants_notify <= stream[send_idx].item.wants_notify;
                    s_notify_tag   <= stream[send_idx].item.notify_tag;
                    s_err_overrun  <= stream[send_idx].item.err_overrun;
                    s_err_framing  <= stream[send_idx].item.err_framing;
                    s_err_noise    <= stream[send_idx].item.err_noise;
                    s_err_dma      <= stream[send_idx].item.err_dma;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each transfer, stall at random and once for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with no expectation pending", $time);
                end else begin
                    want_now = awaited_results.pop_front();
                    check_field("status", 32'(want_now.status), 32'(m_status));
                    check_field("start_valid", 32'(want_now.start_valid), 32'(m_start_valid));
                    check_field("start_addr", want_now.start_addr, m_start_addr);
                    check_field("start_count", 32'(want_now.start_count), 32'(m_start_count));
                    check_field("done_valid", 32'(want_now.done_valid), 32'(m_done_valid));
                    check_field("done_tag", want_now.done_tag, m_done_tag);
                    check_field("done_count", 32'(want_now.done_count), 32'(m_done_count));
                    check_field("overrun_total", want_now.overrun_total, m_overrun_total);
                    check_field("framing_total", want_now.framing_total, m_framing_total);
                    check_field("noise_total", want_now.noise_total, m_noise_total);
                    check_field("pending_level", 32'(want_now.pending_level),
                                32'(m_pending_level));
                    check_field("busy_now", 32'(want_now.busy_now), 32'(m_busy_now));
                end
                if (m_status == ST_BUSY) n_busy++;
                if (m_status == ST_FAULT) n_fault++;
                if (m_done_valid) n_notice++;
                if (m_start_valid) n_start++;
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!stall_done && results_seen >= STALL_AFTER) begin
                // hold off long enough for the block to back up into its input
                hold_left  <= STALL_CYCLES;
                stall_done <= 1'b1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= calm || $urandom_range(0, 99) >= 24;
            end
        end
    end

    initial begin : main_seq
        sched_result_t idle_res;
        cmd_item_t it;
        logic [31:0] w;
        int submit_pct;
        int pick;

        idle_res = mk_res(ST_OK, 1'b0, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0);

        // directed table
        add_row(mk_cmd(CMD_DONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'b0000),
                1'b1, idle_res);
        add_row(mk_cmd(CMD_ERROR, 32'h0, 16'h0, 1'b0, 32'h0, 4'b0001), 1'b1, idle_res);
        add_row(mk_cmd(CMD_SUBMIT, 32'h0, 16'hFFFF, 1'b1, 32'h1234_5678, 4'b0000), 1'b1,
                mk_res(ST_FAULT, 1'b0, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0));
        add_row(mk_cmd(CMD_SUBMIT, 32'hFFFF_FFFF, 16'h0, 1'b1, 32'h1, 4'b0000), 1'b1,
                mk_res(ST_FAULT, 1'b0, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0));
        add_row(mk_cmd(CMD_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'b0000),
                1'b1, mk_res(ST_OK, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0, '0,
                             '0, '0, '0, '0, 1'b1));
        for (int k = 1; k <= QUEUE_DEPTH_DEF; k++) begin
            add_row(mk_cmd(CMD_SUBMIT, {4'(k), 28'(k)}, 16'(k), 1'(k), ~32'(k), 4'b0000),
                    1'b0, idle_res);
        end
        add_row(mk_cmd(CMD_SUBMIT, 32'h1, 16'h1, 1'b0, 32'h0, 4'b0000), 1'b1,
                mk_res(ST_BUSY, 1'b0, '0, '0, 1'b0, '0, '0, '0, '0, '0, 4'd8, 1'b1));
        add_row(mk_cmd(CMD_SUBMIT, 32'h0, 16'h0, 1'b1, 32'hFFFF_FFFF, 4'b1111), 1'b1,
                mk_res(ST_FAULT, 1'b0, '0, '0, 1'b0, '0, '0, '0, '0, '0, 4'd8, 1'b1));
        add_row(mk_cmd(CMD_DONE, 32'h0, 16'h0, 1'b0, 32'h0, 4'b0000), 1'b0, idle_res);
        add_row(mk_cmd(CMD_ERROR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'b1111),
                1'b0, idle_res);
        add_row(mk_cmd(CMD_ERROR, 32'h0, 16'h0, 1'b0, 32'h0, 4'b0000), 1'b0, idle_res);
        add_row(mk_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'b1111),
                1'b0, idle_res);
        add_row(mk_cmd(CMD_ERROR, 32'h0, 16'h0, 1'b0, 32'h0, 4'b1000), 1'b0, idle_res);
        add_row(mk_cmd(CMD_ERROR, 32'h0, 16'h0, 1'b0, 32'h0, 4'b0100), 1'b0, idle_res);
        add_row(mk_cmd(CMD_ERROR, 32'h0, 16'h0, 1'b0, 32'h0, 4'b0010), 1'b0, idle_res);
        add_row(mk_cmd(CMD_DONE, 32'h0, 16'h0, 1'b0, 32'h0, 4'b0000), 1'b0, idle_res);

        // random part: the submit share drifts so the queue both fills and drains
        submit_pct = 50;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 64 == 0) submit_pct = $urandom_range(25, 75);
            w  = rand_word();
            it = mk_cmd(CMD_SUBMIT, rand_word(), w[15:0], 1'($urandom_range(0, 1)),
                        rand_word(), 4'($urandom));
            if ($urandom_range(0, 99) < submit_pct) begin
                if ($urandom_range(0, 9) == 0) begin
                    // broken descriptor: zero address or zero length
                    if ($urandom_range(0, 1) == 0) it.buf_addr = '0;
                    else it.byte_count = '0;
                end else begin
                    if (it.buf_addr == '0) it.buf_addr = 32'h4;
                    if (it.byte_count == '0) it.byte_count = 16'h1;
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) it.command = CMD_DONE;
                else if (pick < 93) it.command = CMD_ERROR;
                else it.command = CMD_UNUSED;
                it.err_dma = ($urandom_range(0, 3) == 0);
            end
            add_row(it, 1'b0, idle_res);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (send_idx < stream.size() || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d commands and %0d checked results: %0d starts, %0d notices,",
                 send_idx, results_seen, n_start, n_notice);
        $display("%0d queue-full refusals, %0d faulted submits, %0d mismatches.",
                 n_busy, n_fault, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/tdq_pkg.sv
sv/tdq_ram.sv
sv/tdq_queue.sv
sv/tx_descriptor_queue_top.sv
bench/tb_top.sv
